@@ rtl/core/pfsr_pkg.sv @@
// pfsr_pkg: shared types and constants of the path segment fifo with step rate division
// used by pfsr_ctrl, pfsr_datapath and the top level, and by the stream interface users
package pfsr_pkg;

	localparam int AXES      = 5;
	localparam int AXIS_W    = 3;
	localparam int COUNT_W   = 16;
	localparam int SEG_W     = AXES * COUNT_W;
	localparam int TIMER_W   = 16;
	localparam int SPACE_W   = 7;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_W     = 16;
	localparam int BIT_W     = 4;

	localparam logic OP_PUSH = 1'b0;
	localparam logic OP_TICK = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_TICK_PERIOD = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_FREE_RUN    = 1'b1;

	localparam logic [TIMER_W-1:0] TICK_PERIOD_RST = 16'd1000;

	typedef struct packed {
		logic               opcode;
		logic signed [15:0] count_a;
		logic signed [15:0] count_b;
		logic signed [15:0] count_c;
		logic signed [15:0] count_d;
		logic signed [15:0] count_e;
	} in_word_t;

	typedef struct packed {
		logic         issued;
		logic [4:0]   dir_mask;
		logic [15:0]  interval_a;
		logic [15:0]  interval_b;
		logic [15:0]  interval_c;
		logic [15:0]  interval_d;
		logic [15:0]  interval_e;
		logic         last_segment;
		logic         motion_stop;
		logic         write_error;
		logic [6:0]   space_left;
	} out_word_t;

	typedef struct packed {
		logic take;
		logic first;
		logic step;
		logic next;
		logic emit;
	} pfsr_cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
		logic bit_last;
		logic axis_last;
	} pfsr_status_t;

endpackage

@@ rtl/core/pfsr_stream_if.sv @@
// pfsr_stream_if: valid/ready channel carrying one word of a given type
// no dependencies; the word type comes from pfsr_pkg at instantiation
interface pfsr_stream_if #(
	parameter type word_t = logic
) ();
	logic  valid;
	logic  ready;
	word_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ rtl/core/pfsr_ram.sv @@
// pfsr_ram: generic single write port ram with one registered read port
// no dependencies
module pfsr_ram #(
	parameter int WIDTH = 80,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

@@ rtl/core/pfsr_ctrl.sv @@
// pfsr_ctrl: sequencer for push, tick and the per axis division passes
// depends on pfsr_pkg for command and status types
module pfsr_ctrl
	import pfsr_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	input  logic         in_opcode,
	output logic         in_ready,
	output logic         out_valid,
	input  logic         out_ready,
	input  pfsr_status_t status,
	output pfsr_cmd_t    cmd
);
	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_FETCH = 4'b0010,
		S_DIV   = 4'b0100,
		S_EMIT  = 4'b1000
	} state_t;

	state_t state_q, state_nxt;
	logic   out_valid_q;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.take = 1'b1;
					if (in_opcode == OP_TICK && !status.empty) begin
						state_nxt = S_FETCH;
					end else begin
						state_nxt = S_EMIT;
					end
				end
			end
			S_FETCH: begin
				cmd.first = 1'b1;
				state_nxt = S_DIV;
			end
			S_DIV: begin
				cmd.step = 1'b1;
				if (status.bit_last) begin
					if (status.axis_last) begin
						state_nxt = S_EMIT;
					end else begin
						cmd.next = 1'b1;
					end
				end
			end
			S_EMIT: begin
				if (!out_valid_q || out_ready) begin
					cmd.emit  = 1'b1;
					state_nxt = S_IDLE;
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end
endmodule

@@ rtl/core/pfsr_datapath.sv @@
// pfsr_datapath: segment store, fifo pointers, config registers, shared divider, result word
// depends on pfsr_pkg and pfsr_ram
module pfsr_datapath
	import pfsr_pkg::*;
#(
	parameter int FIFO_DEPTH = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  in_word_t             in_word,
	output out_word_t            out_word,
	input  pfsr_cmd_t            cmd,
	output pfsr_status_t         status
);
	localparam int IW = $clog2(FIFO_DEPTH);
	localparam int FW = $clog2(FIFO_DEPTH + 1);
	localparam int SW = (FW > SPACE_W) ? FW : SPACE_W;

	logic [TIMER_W-1:0] tick_period_q;
	logic               free_run_q;
	logic [IW-1:0]      wr_idx_q, rd_idx_q;
	logic [FW-1:0]      fill_q, fill_nxt;
	logic               full, empty, is_push, do_push, do_pop;
	logic [SEG_W-1:0]   seg_rd, seg_wr;
	logic [SW-1:0]      space_diff;

	logic               issued_q, last_q, stop_q, err_q;
	logic [SPACE_W-1:0] space_q;
	logic [AXES-1:0]    dir_q;
	logic [15:0]        ival_q [AXES];

	logic [AXIS_W-1:0]  axis_q;
	logic [BIT_W-1:0]   bit_q;
	logic [16:0]        rem_q;
	logic [15:0]        quo_q;
	logic [15:0]        raw;
	logic [16:0]        mag, sh, rem_n;
	logic [17:0]        diff;
	logic [15:0]        quo_n;
	logic               ge;

	assign full    = (fill_q == FW'(FIFO_DEPTH));
	assign empty   = (fill_q == '0);
	assign is_push = (in_word.opcode == OP_PUSH);
	assign do_push = cmd.take && is_push && !full;
	assign do_pop  = cmd.take && !is_push && !empty;

	assign seg_wr = {in_word.count_e, in_word.count_d, in_word.count_c,
		in_word.count_b, in_word.count_a};

	always_comb begin
		fill_nxt = fill_q;
		if (do_push) begin
			fill_nxt = fill_q + 1'b1;
		end else if (do_pop) begin
			fill_nxt = fill_q - 1'b1;
		end
	end

	assign space_diff = SW'(FIFO_DEPTH) - SW'(fill_nxt);

	pfsr_ram #(
		.WIDTH(SEG_W),
		.DEPTH(FIFO_DEPTH)
	) u_store (
		.clk  (clk),
		.we   (do_push),
		.waddr(wr_idx_q),
		.wdata(seg_wr),
		.re   (do_pop),
		.raddr(rd_idx_q),
		.rdata(seg_rd)
	);

	// axis select and divider step
	always_comb begin
		case (axis_q)
			3'd0:    raw = seg_rd[15:0];
			3'd1:    raw = seg_rd[31:16];
			3'd2:    raw = seg_rd[47:32];
			3'd3:    raw = seg_rd[63:48];
			3'd4:    raw = seg_rd[79:64];
			default: raw = '0;
		endcase
	end

	assign mag   = raw[15] ? (17'h10000 - {1'b0, raw}) : {1'b0, raw};
	assign sh    = {rem_q[15:0], quo_q[15]};
	assign diff  = {1'b0, sh} - {1'b0, mag};
	assign ge    = !diff[17];
	assign rem_n = ge ? diff[16:0] : sh;
	assign quo_n = {quo_q[14:0], ge};

	assign status.full      = full;
	assign status.empty     = empty;
	assign status.bit_last  = (bit_q == '0);
	assign status.axis_last = (axis_q == AXIS_W'(AXES - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_period_q <= TICK_PERIOD_RST;
			free_run_q    <= 1'b0;
			wr_idx_q      <= '0;
			rd_idx_q      <= '0;
			fill_q        <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_TICK_PERIOD: tick_period_q <= cfg_data[TIMER_W-1:0];
					REG_FREE_RUN:    free_run_q    <= cfg_data[0];
					default:         ;
				endcase
			end
			if (do_push) begin
				wr_idx_q <= (wr_idx_q == IW'(FIFO_DEPTH - 1)) ? '0 : wr_idx_q + 1'b1;
			end
			if (do_pop) begin
				rd_idx_q <= (rd_idx_q == IW'(FIFO_DEPTH - 1)) ? '0 : rd_idx_q + 1'b1;
			end
			fill_q <= fill_nxt;
		end
	end

	// working result and divider registers
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			issued_q <= do_pop;
			last_q   <= do_pop && (fill_q == FW'(1));
			stop_q   <= do_pop && (fill_q == FW'(1)) && !free_run_q;
			err_q    <= is_push && full;
			space_q  <= space_diff[SPACE_W-1:0];
			dir_q    <= '0;
			for (int i = 0; i < AXES; i++) begin
				ival_q[i] <= '0;
			end
		end
		if (cmd.first) begin
			for (int i = 0; i < AXES; i++) begin
				dir_q[i] <= seg_rd[i*COUNT_W + COUNT_W - 1];
			end
		end
		if (cmd.step && bit_q == '0) begin
			ival_q[axis_q] <= (mag == '0) ? '0 : quo_n;
		end
		if (cmd.first || cmd.next) begin
			axis_q <= cmd.first ? '0 : axis_q + 1'b1;
			rem_q  <= '0;
			quo_q  <= tick_period_q;
			bit_q  <= BIT_W'(TIMER_W - 1);
		end else if (cmd.step) begin
			rem_q <= rem_n;
			quo_q <= quo_n;
			bit_q <= bit_q - 1'b1;
		end
		if (cmd.emit) begin
			out_word.issued       <= issued_q;
			out_word.dir_mask     <= dir_q;
			out_word.interval_a   <= ival_q[0];
			out_word.interval_b   <= ival_q[1];
			out_word.interval_c   <= ival_q[2];
			out_word.interval_d   <= ival_q[3];
			out_word.interval_e   <= ival_q[4];
			out_word.last_segment <= last_q;
			out_word.motion_stop  <= stop_q;
			out_word.write_error  <= err_q;
			out_word.space_left   <= space_q;
		end
	end
endmodule

@@ rtl/core/path_fifo_step_rate.sv @@
// path_fifo_step_rate: top level of the five axis path segment fifo with step interval division
// depends on pfsr_pkg, pfsr_stream_if, pfsr_ctrl and pfsr_datapath
//
// Segments pushed on req are held in a FIFO_DEPTH entry ram; every word gives one result word
// on rsp. A push or a tick on an empty fifo goes from acceptance to the emit state. A tick that
// pops a segment does one ram read, then a shared restoring divider works out the tick period
// / |count| one quotient bit per cycle, a 16-bit quotient for each of the five axes in turn.
// One word is in work at a time; the next is accepted once the result is in the output register,
// even if rsp has not taken it yet. The user must write the tick period and free run registers
// through cfg_we / cfg_index / cfg_data only while the block is idle; it does not enforce this.
module path_fifo_step_rate
	import pfsr_pkg::*;
#(
	parameter int FIFO_DEPTH = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	pfsr_stream_if.sink          req,
	pfsr_stream_if.source        rsp
);
	pfsr_cmd_t    cmd;
	pfsr_status_t status;
	in_word_t     in_word;
	out_word_t    out_word;

	assign in_word  = req.data;
	assign rsp.data = out_word;

	pfsr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_opcode(in_word.opcode),
		.in_ready (req.ready),
		.out_valid(rsp.valid),
		.out_ready(rsp.ready),
		.status   (status),
		.cmd      (cmd)
	);

	pfsr_datapath #(
		.FIFO_DEPTH(FIFO_DEPTH)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.in_word  (in_word),
		.out_word (out_word),
		.cmd      (cmd),
		.status   (status)
	);
endmodule
